/* sv/wpd_pkg.sv */
`default_nettype none
package wpd_pkg;

	localparam int unsigned HEADER_BYTES = 44;

	localparam logic [5:0] OFF_CHAN_LO = 6'd22;
	localparam logic [5:0] OFF_CHAN_HI = 6'd23;
	localparam logic [5:0] OFF_RATE_0  = 6'd24;
	localparam logic [5:0] OFF_RATE_3  = 6'd27;
	localparam logic [5:0] OFF_BITS_LO = 6'd34;
	localparam logic [5:0] OFF_BITS_HI = 6'd35;
	localparam logic [5:0] OFF_SIZE_0  = 6'd40;
	localparam logic [5:0] OFF_SIZE_3  = 6'd43;
	localparam logic [5:0] OFF_LAST    = 6'(HEADER_BYTES - 1);

	localparam logic [15:0] BITS_8  = 16'd8;
	localparam logic [15:0] BITS_16 = 16'd16;
	localparam logic [15:0] BITS_32 = 16'd32;

	localparam logic [31:0] PCM8_BIAS = 32'hFFFF_FF80;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DATA   = 2'd1,
		PH_IDLE   = 2'd2
	} phase_t;

	// bytes per sample for the supported widths, zero otherwise
	function automatic logic [2:0] sample_bytes(input logic [15:0] bits);
		logic [2:0] sb;
		case (bits)
			BITS_8:  sb = 3'd1;
			BITS_16: sb = 3'd2;
			BITS_32: sb = 3'd4;
			default: sb = 3'd0;
		endcase
		return sb;
	endfunction

	function automatic logic [31:0] decode(input logic [15:0] bits, input logic [31:0] acc);
		logic [31:0] biased;
		logic [31:0] res;
		biased = {24'd0, acc[7:0]} + PCM8_BIAS;
		case (bits)
			BITS_8:  res = {biased[23:0], 8'd0};
			BITS_16: res = {{16{acc[15]}}, acc[15:0]};
			default: res = acc;
		endcase
		return res;
	endfunction

endpackage
`default_nettype wire

/* sv/wpd_ifs.sv */
`default_nettype none
interface wpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;

	modport source (output valid, output data_byte, output file_start, input ready);
	modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

interface wpd_frame_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] right_sample;
	logic signed [31:0] left_sample;
	logic               last_frame;
	logic               bad_format;
	logic        [15:0] channels;
	logic        [31:0] rate_word;
	logic        [15:0] sample_bits;

	modport source (output valid, output right_sample, output left_sample,
		output last_frame, output bad_format, output channels, output rate_word,
		output sample_bits, input ready);
	modport sink (input valid, input right_sample, input left_sample,
		input last_frame, input bad_format, input channels, input rate_word,
		input sample_bits, output ready);
endinterface
`default_nettype wire

/* sv/wav_pcm_stream_decoder.sv */
`default_nettype none
// Channel  Dir  Carries
// stream   in   one file byte per word, file_start marks header byte 0
// frame    out  one decoded frame (right, left) or one format error per word
//
// A word may enter on every clock while stream is ready.
// Header fields and frame samples are gathered in state registers; a result
// leaves through a single output register, so stream stays ready while that
// register is empty or being drained in the same cycle.
// arst_n clears all parse state; the first byte after reset is header byte 0.
// A stall on frame holds the result and stops stream only while it lasts.
module wav_pcm_stream_decoder (
	input wire logic   clk,
	input wire logic   arst_n,
	wpd_byte_if.sink   stream,
	wpd_frame_if.source frame
);
	import wpd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [5:0]  hcount_q, hcount_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] bits_q, bits_d;
	logic [31:0] left_q, left_d;
	logic [15:0] fidx_q, fidx_d;
	logic [1:0]  lane_q, lane_d;
	logic [31:0] racc_q, racc_d;
	logic [31:0] lacc_q, lacc_d;

	logic        ovalid_q;
	logic [31:0] oright_q, oleft_q, orate_q;
	logic        olast_q, obad_q;
	logic [15:0] ochan_q, obits_q;

	logic        take;
	logic        emit;
	logic        emit_bad;
	logic [31:0] res_right, res_left;
	logic        res_last;

	// view of the state after a file_start restart
	phase_t      ph_e;
	logic [5:0]  hc_e;
	logic [15:0] fidx_e;
	logic [1:0]  lane_e;
	logic [31:0] racc_e, lacc_e;

	logic [2:0]  sb;
	logic [4:0]  sh;
	logic [31:0] byte_sh;
	logic [2:0]  lane_inc;
	logic [16:0] fidx_inc;
	logic [17:0] frame_len;
	logic        fmt_ok;

	assign stream.ready = !ovalid_q || frame.ready;
	assign take = stream.valid && stream.ready;

	assign ph_e   = stream.file_start ? PH_HEADER : phase_q;
	assign hc_e   = stream.file_start ? 6'd0 : hcount_q;
	assign fidx_e = stream.file_start ? 16'd0 : fidx_q;
	assign lane_e = stream.file_start ? 2'd0 : lane_q;
	assign racc_e = stream.file_start ? 32'd0 : racc_q;
	assign lacc_e = stream.file_start ? 32'd0 : lacc_q;

	assign sb       = sample_bytes(bits_q);
	assign sh       = {lane_e, 3'd0};
	assign byte_sh  = {24'd0, stream.data_byte} << sh;
	assign lane_inc = {1'b0, lane_e} + 3'd1;
	assign fidx_inc = {1'b0, fidx_e} + 17'd1;
	assign fmt_ok   = (sb != 3'd0) && (chan_q != 16'd0);

	always_comb begin
		case (sb)
			3'd2:    frame_len = {1'b0, chan_q, 1'b0};
			3'd4:    frame_len = {chan_q, 2'b00};
			default: frame_len = {2'b00, chan_q};
		endcase
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (take) begin
			phase_d = ph_e;
			if (ph_e == PH_HEADER && hc_e == OFF_LAST) begin
				phase_d = fmt_ok ? PH_DATA : PH_IDLE;
			end
		end
	end

	// header capture and frame assembly
	always_comb begin
		hcount_d  = hcount_q;
		chan_d    = chan_q;
		rate_d    = rate_q;
		bits_d    = bits_q;
		left_d    = left_q;
		fidx_d    = fidx_q;
		lane_d    = lane_q;
		racc_d    = racc_q;
		lacc_d    = lacc_q;
		emit      = 1'b0;
		emit_bad  = 1'b0;
		res_right = 32'd0;
		res_left  = 32'd0;
		res_last  = 1'b1;
		if (take) begin
			hcount_d = hc_e;
			fidx_d   = fidx_e;
			lane_d   = lane_e;
			racc_d   = racc_e;
			lacc_d   = lacc_e;
			if (ph_e == PH_HEADER) begin
				if (hc_e == OFF_CHAN_LO) chan_d[7:0] = stream.data_byte;
				if (hc_e == OFF_CHAN_HI) chan_d[15:8] = stream.data_byte;
				if (hc_e >= OFF_RATE_0 && hc_e <= OFF_RATE_3) begin
					rate_d[{hc_e[1:0], 3'd0} +: 8] = stream.data_byte;
				end
				if (hc_e == OFF_BITS_LO) bits_d[7:0] = stream.data_byte;
				if (hc_e == OFF_BITS_HI) bits_d[15:8] = stream.data_byte;
				if (hc_e >= OFF_SIZE_0 && hc_e <= OFF_SIZE_3) begin
					// 40..43 have low bits 00..11
					left_d[{hc_e[1:0], 3'd0} +: 8] = stream.data_byte;
				end
				if (hc_e == OFF_LAST) begin
					hcount_d = 6'd0;
					fidx_d   = 16'd0;
					lane_d   = 2'd0;
					racc_d   = 32'd0;
					lacc_d   = 32'd0;
					if (!fmt_ok) begin
						emit     = 1'b1;
						emit_bad = 1'b1;
					end
				end else begin
					hcount_d = hc_e + 6'd1;
				end
			end else if (ph_e == PH_DATA && left_q != 32'd0) begin
				left_d = left_q - 32'd1;
				if (fidx_e == 16'd0) racc_d = racc_e | byte_sh;
				if (fidx_e == {1'b0, chan_q[15:1]}) lacc_d = lacc_e | byte_sh;
				lane_d = lane_inc[1:0];
				if (lane_inc >= sb) begin
					lane_d = 2'd0;
					fidx_d = fidx_inc[15:0];
					if (fidx_inc >= {1'b0, chan_q}) begin
						fidx_d    = 16'd0;
						racc_d    = 32'd0;
						lacc_d    = 32'd0;
						emit      = 1'b1;
						res_right = decode(bits_q, (fidx_e == 16'd0)
							? racc_e | byte_sh : racc_e);
						res_left  = decode(bits_q, (fidx_e == {1'b0, chan_q[15:1]})
							? lacc_e | byte_sh : lacc_e);
						res_last  = {14'd0, frame_len} > left_d;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hcount_q <= '0;
			chan_q   <= '0;
			rate_q   <= '0;
			bits_q   <= '0;
			left_q   <= '0;
			fidx_q   <= '0;
			lane_q   <= '0;
			racc_q   <= '0;
			lacc_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			hcount_q <= hcount_d;
			chan_q   <= chan_d;
			rate_q   <= rate_d;
			bits_q   <= bits_d;
			left_q   <= left_d;
			fidx_q   <= fidx_d;
			lane_q   <= lane_d;
			racc_q   <= racc_d;
			lacc_q   <= lacc_d;
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (frame.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// result word: load on emit, hold while stalled
	always_ff @(posedge clk) begin
		if (emit) begin
			oright_q <= res_right;
			oleft_q  <= res_left;
			olast_q  <= res_last;
			obad_q   <= emit_bad;
			ochan_q  <= chan_q;
			orate_q  <= rate_q;
			obits_q  <= bits_q;
		end
	end

	assign frame.valid        = ovalid_q;
	assign frame.right_sample = oright_q;
	assign frame.left_sample  = oleft_q;
	assign frame.last_frame   = olast_q;
	assign frame.bad_format   = obad_q;
	assign frame.channels     = ochan_q;
	assign frame.rate_word    = orate_q;
	assign frame.sample_bits  = obits_q;

	a_bad_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.bad_format |->
			frame.last_frame && frame.right_sample == 0 && frame.left_sample == 0)
		else $error("format error word carries samples");

	a_idle_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |=> phase_q != PH_DATA)
		else $error("idle parser entered data phase");

	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> {1'b0, lane_q} < sb)
		else $error("lane outside sample");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> fidx_q < chan_q)
		else $error("channel index outside frame");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> frame.valid)
		else $error("stream stalled with empty output register");

endmodule
`default_nettype wire

/* tb/tb_wav_pcm_stream_decoder.sv */
`timescale 1ns / 1ps
module tb_wav_pcm_stream_decoder;
	import wpd_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       start;
		logic       hold;
	} byte_item_t;

	typedef struct packed {
		logic signed [31:0] right_smp;
		logic signed [31:0] left_smp;
		logic               last;
		logic               bad;
		logic        [15:0] chans;
		logic        [31:0] rate;
		logic        [15:0] bits;
	} frame_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_CHOPPY,
		RX_SPARSE
	} rx_mode_t;

	logic clk;
	logic arst_n;

	wpd_byte_if  stream_if ();
	wpd_frame_if frame_if ();

	wav_pcm_stream_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.frame  (frame_if)
	);

	byte_item_t pending_bytes[$];
	frame_t     frames_due[$];

	// decoder state as the byte stream advances it
	logic [5:0]  hdr_pos;
	logic [15:0] chan_cnt;
	logic [31:0] rate_val;
	logic [15:0] width_val;
	logic [31:0] data_left;
	logic [16:0] chan_idx;
	int unsigned lane;
	logic [31:0] right_acc;
	logic [31:0] left_acc;
	phase_t      phase;

	int n_err;
	int bytes_taken;
	int files_queued;
	int frames_seen;
	int bad_seen;
	int burst_left;
	int gap_left;
	int rx_seen;
	int mode_left;
	int hold_left;
	logic long_done;
	rx_mode_t rx_mode;
	byte_item_t cur;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] to_pcm(input logic [31:0] acc);
		int v;
		if (width_val == BITS_8)
			v = (int'(acc[7:0]) - 128) * 256;
		else if (width_val == BITS_16)
			v = int'(shortint'(acc[15:0]));
		else
			v = int'(acc);
		return v;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic start);
		int unsigned sb;
		logic ok;
		frame_t f;
		if (start) begin
			hdr_pos = '0;
			chan_idx = '0;
			lane = 0;
			right_acc = '0;
			left_acc = '0;
			phase = PH_HEADER;
		end
		if (phase == PH_HEADER) begin
			case (hdr_pos)
				OFF_CHAN_LO: chan_cnt[7:0] = b;
				OFF_CHAN_HI: chan_cnt[15:8] = b;
				OFF_BITS_LO: width_val[7:0] = b;
				OFF_BITS_HI: width_val[15:8] = b;
				default: ;
			endcase
			if (hdr_pos >= OFF_RATE_0 && hdr_pos <= OFF_RATE_3)
				rate_val[8 * int'(hdr_pos - OFF_RATE_0) +: 8] = b;
			if (hdr_pos >= OFF_SIZE_0 && hdr_pos <= OFF_SIZE_3)
				data_left[8 * int'(hdr_pos - OFF_SIZE_0) +: 8] = b;
			if (hdr_pos == OFF_LAST) begin
				ok = (width_val == BITS_8 || width_val == BITS_16 || width_val == BITS_32)
					&& chan_cnt != 16'd0;
				hdr_pos = '0;
				chan_idx = '0;
				lane = 0;
				right_acc = '0;
				left_acc = '0;
				if (ok) begin
					phase = PH_DATA;
				end else begin
					phase = PH_IDLE;
					f.right_smp = '0;
					f.left_smp = '0;
					f.last = 1'b1;
					f.bad = 1'b1;
					f.chans = chan_cnt;
					f.rate = rate_val;
					f.bits = width_val;
					frames_due.push_back(f);
				end
			end else begin
				hdr_pos++;
			end
		end else if (phase == PH_DATA && data_left != 32'd0) begin
			sb = width_val >> 3;
			data_left--;
			if (chan_idx == 17'd0)
				right_acc[8 * lane +: 8] = b;
			if (chan_idx == 17'(chan_cnt >> 1))
				left_acc[8 * lane +: 8] = b;
			lane++;
			if (lane >= sb) begin
				lane = 0;
				chan_idx++;
				if (chan_idx >= 17'(chan_cnt)) begin
					f.right_smp = to_pcm(right_acc);
					f.left_smp = to_pcm(left_acc);
					f.last = data_left < sb * chan_cnt;
					f.bad = 1'b0;
					f.chans = chan_cnt;
					f.rate = rate_val;
					f.bits = width_val;
					frames_due.push_back(f);
					chan_idx = '0;
					right_acc = '0;
					left_acc = '0;
				end
			end
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic start, input logic hold = 1'b0);
		byte_item_t it;
		it.data = b;
		it.start = start;
		it.hold = hold;
		pending_bytes.push_back(it);
	endtask

	task automatic queue_random(input int n, input int start_odds = 0);
		for (int i = 0; i < n; i++)
			queue_byte(8'($urandom_range(0, 255)),
				start_odds != 0 && $urandom_range(0, start_odds - 1) == 0);
	endtask

	// upto below the full header length cuts the header short
	task automatic queue_header(input logic [15:0] chans, input logic [15:0] bits,
		input logic [31:0] rate, input logic [31:0] size, input logic start,
		input logic hold = 1'b0, input int upto = HEADER_BYTES);
		logic [7:0] b;
		for (int i = 0; i < upto; i++) begin
			b = 8'($urandom_range(0, 255));
			case (6'(i))
				OFF_CHAN_LO: b = chans[7:0];
				OFF_CHAN_HI: b = chans[15:8];
				OFF_BITS_LO: b = bits[7:0];
				OFF_BITS_HI: b = bits[15:8];
				default: ;
			endcase
			if (i >= OFF_RATE_0 && i <= OFF_RATE_3)
				b = rate[8 * (i - OFF_RATE_0) +: 8];
			if (i >= OFF_SIZE_0 && i <= OFF_SIZE_3)
				b = size[8 * (i - OFF_SIZE_0) +: 8];
			queue_byte(b, i == 0 ? start : 1'b0, i == 0 ? hold : 1'b0);
		end
		files_queued++;
	endtask

	task automatic queue_good_file;
		logic [15:0] chans;
		logic [15:0] bits;
		int sel;
		int fb;
		int size;
		sel = $urandom_range(0, 9);
		chans = sel < 4 ? 16'd1 : sel < 7 ? 16'd2 : sel == 7 ? 16'd3 : sel == 8 ? 16'd4
			: 16'($urandom_range(5, 12));
		sel = $urandom_range(0, 2);
		bits = sel == 0 ? BITS_8 : sel == 1 ? BITS_16 : BITS_32;
		fb = int'(bits >> 3) * int'(chans);
		size = fb * $urandom_range(1, 6);
		if (fb > 1 && $urandom_range(0, 3) == 0)
			size += $urandom_range(1, fb - 1);
		queue_header(chans, bits, $urandom_range(0, 1) ? 32'd48000 : $urandom(), size,
			1'b1, $urandom_range(0, 19) == 0);
		sel = $urandom_range(0, 19);
		if (sel < 14) begin
			queue_random(size);
		end else if (sel < 17) begin
			queue_random(size);
			queue_random($urandom_range(1, 4));
		end else begin
			queue_random($urandom_range(0, size - 1));
		end
	endtask

	task automatic queue_bad_file;
		logic [15:0] chans;
		logic [15:0] bits;
		chans = 16'($urandom_range(1, 65535));
		case ($urandom_range(0, 3))
			0: bits = 16'd24;
			1: begin
				chans = '0;
				bits = $urandom_range(0, 1) ? BITS_16 : BITS_8;
			end
			2: bits = 16'($urandom_range(0, 65535));
			default: bits = {8'($urandom_range(1, 255)), BITS_16[7:0]};
		endcase
		queue_header(chans, bits, $urandom(), $urandom(), 1'b1);
		queue_random($urandom_range(0, 4));
	endtask

	// sender: bursts of random length, random gaps, hold items wait for a drained scoreboard
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_if.valid <= 1'b0;
			stream_if.data_byte <= '0;
			stream_if.file_start <= 1'b0;
			burst_left = 0;
			gap_left = 0;
			hdr_pos = '0;
			chan_cnt = '0;
			rate_val = '0;
			width_val = '0;
			data_left = '0;
			chan_idx = '0;
			lane = 0;
			right_acc = '0;
			left_acc = '0;
			phase = PH_HEADER;
		end else begin
			if (stream_if.valid && stream_if.ready) begin
				decode_byte(stream_if.data_byte, stream_if.file_start);
				bytes_taken++;
			end
			if (!stream_if.valid || stream_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					stream_if.valid <= 1'b0;
				end else if (pending_bytes.size() != 0
					&& !(pending_bytes[0].hold && frames_due.size() != 0)) begin
					cur = pending_bytes.pop_front();
					stream_if.valid <= 1'b1;
					stream_if.data_byte <= cur.data;
					stream_if.file_start <= cur.start;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
					end
				end else begin
					stream_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: windows of open, choppy and sparse ready, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_if.ready <= 1'b0;
			rx_seen = 0;
			mode_left = 0;
			hold_left = 0;
			long_done = 1'b0;
			rx_mode = RX_OPEN;
		end else begin
			if (frame_if.valid && frame_if.ready)
				rx_seen++;
			if (!long_done && rx_seen >= 30) begin
				long_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				frame_if.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (rx_mode)
					RX_OPEN:   frame_if.ready <= 1'b1;
					RX_CHOPPY: frame_if.ready <= 1'($urandom_range(0, 1));
					default:   frame_if.ready <= $urandom_range(0, 3) == 0;
				endcase
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			n_err++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		frame_t exp_f;
		if (arst_n && frame_if.valid && frame_if.ready) begin
			frames_seen++;
			if (frame_if.bad_format)
				bad_seen++;
			if (frames_due.size() == 0) begin
				n_err++;
				$display("%0t: unexpected word expected none actual right %0h left %0h bad %0b",
					$time, frame_if.right_sample, frame_if.left_sample, frame_if.bad_format);
			end else begin
				exp_f = frames_due.pop_front();
				check_field("right_sample", exp_f.right_smp, frame_if.right_sample);
				check_field("left_sample", exp_f.left_smp, frame_if.left_sample);
				check_field("last_frame", 32'(exp_f.last), 32'(frame_if.last_frame));
				check_field("bad_format", 32'(exp_f.bad), 32'(frame_if.bad_format));
				check_field("channels", 32'(exp_f.chans), 32'(frame_if.channels));
				check_field("rate_word", exp_f.rate, frame_if.rate_word);
				check_field("sample_bits", 32'(exp_f.bits), 32'(frame_if.sample_bits));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("%0t: run did not finish in time", $time);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		stream_if.valid = 1'b0;
		stream_if.data_byte = '0;
		stream_if.file_start = 1'b0;
		frame_if.ready = 1'b0;
		n_err = 0;
		bytes_taken = 0;
		files_queued = 0;
		frames_seen = 0;
		bad_seen = 0;

		// first file after reset carries no start flag; 8-bit extremes, then spare bytes
		queue_header(16'd1, BITS_8, 32'd0, 32'd4, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_random(2);
		// stereo 16-bit with a partial final frame
		queue_header(16'd2, BITS_16, 32'd44100, 32'd9, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h5A, 1'b0);
		// three channels of 32 bits, left is channel 1
		queue_header(16'd3, BITS_32, 32'hFFFF_FFFF, 32'd24, 1'b1, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_random(16);
		// restart in the middle of a frame
		queue_header(16'd2, BITS_8, 32'd8000, 32'd100, 1'b1);
		queue_random(3);
		// unsupported widths and zero channels, idle bytes in between
		queue_header(16'd2, 16'd24, 32'd96000, 32'd64, 1'b1);
		queue_random(3);
		queue_header(16'd0, BITS_16, 32'd22050, 32'd64, 1'b1, 1'b1);
		queue_header(16'hFFFF, 16'hFFFF, 32'h8000_0001, 32'hFFFF_FFFF, 1'b1);
		// restart inside the header, then a wide frame that never completes
		queue_header(16'd1, BITS_8, 32'd1, 32'd8, 1'b1, 1'b0, 10);
		queue_header(16'hFFFF, BITS_8, 32'hFFFF_FFFF, 32'd3, 1'b1);
		queue_random(3);

		while (pending_bytes.size() < 1200) begin
			case ($urandom_range(0, 19))
				0, 1, 2: queue_bad_file();
				3, 4: queue_header(16'($urandom()), 16'($urandom()), $urandom(), $urandom(),
					1'b1, 1'b0, int'($urandom_range(1, HEADER_BYTES - 1)));
				5: queue_random($urandom_range(1, 16), 8);
				default: queue_good_file();
			endcase
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() != 0 || stream_if.valid)
			@(posedge clk);
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d bytes over %0d files: %0d words checked, %0d of them format errors",
			bytes_taken, files_queued, frames_seen, bad_seen);
		$display("output stalls, one long hold-off and drained pauses between files included");
		if (n_err == 0 && frames_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
